>>> hdl/akf_pkg.sv
// ----------------------------------------------------------------------------
// akf_pkg
// Shared types, constants and saturation helper of the angle Kalman filter.
// ----------------------------------------------------------------------------
`default_nettype none
package akf_pkg;

   localparam int unsigned DataWidth = 32;
   localparam int unsigned NoiseWidth = 31;
   localparam int unsigned DtWidth = 24;
   localparam int unsigned CsrIdxWidth = 2;

   localparam logic [CsrIdxWidth-1:0] CSR_ANGLE_Q = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_BIAS_Q  = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_MEAS_R  = 2'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_START   = 2'd3;

   localparam logic [NoiseWidth-1:0] ANGLE_Q_RESET = 31'd268435;
   localparam logic [NoiseWidth-1:0] BIAS_Q_RESET  = 31'd805306;
   localparam logic [NoiseWidth-1:0] MEAS_R_RESET  = 31'd8053064;

   // Multiplier shift select: which rounding shift applies to the product.
   typedef enum logic [1:0] {
      SHIFT_24 = 2'd0,
      SHIFT_28 = 2'd1
   } shift_type;

   typedef struct packed {
      logic signed [DataWidth:0] a;
      logic signed [DataWidth:0] b;
      shift_type                 shift;
   } mul_req_type;

   // Saturate a wide signed value to 32 bits.
   function automatic logic signed [DataWidth-1:0] sat32(input logic signed [67:0] v);
      logic signed [67:0] hi;
      logic signed [67:0] lo;
      hi = 68'sh7FFFFFFF;
      lo = -68'sh80000000;
      if (v > hi) begin
         sat32 = 32'sh7FFFFFFF;
      end else if (v < lo) begin
         sat32 = 32'sh80000000;
      end else begin
         sat32 = v[DataWidth-1:0];
      end
   endfunction

endpackage
`default_nettype wire

>>> hdl/akf_mul.sv
// ----------------------------------------------------------------------------
// akf_mul
// Shared signed multiplier with a registered product and a registered
// rounding right shift (to nearest, ties away from zero) by 24 or 28 bits.
// ----------------------------------------------------------------------------
`default_nettype none
module akf_mul
   import akf_pkg::*;
(
   input  wire logic                clock,
   input  wire mul_req_type         req,
   output logic signed [67:0]       result
);

   logic signed [65:0] prod_ff;
   logic signed [65:0] prod_in;
   shift_type          shift_ff;
   logic [65:0]        mag;
   logic [65:0]        rnd;
   logic signed [67:0] result_ff;
   logic signed [67:0] result_in;

   assign prod_in = 66'(req.a) * 66'(req.b);

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      shift_ff  <= req.shift;
      result_ff <= result_in;
   end

   always_comb begin
      mag = prod_ff[65] ? 66'(-prod_ff) : 66'(prod_ff);
      case (shift_ff)
         SHIFT_24: rnd = (mag + 66'(1 << 23)) >> 24;
         SHIFT_28: rnd = (mag + 66'(1 << 27)) >> 28;
         default:  rnd = (mag + 66'(1 << 23)) >> 24;
      endcase
      result_in = prod_ff[65] ? -68'(rnd) : 68'(rnd);
   end

   assign result = result_ff;

endmodule
`default_nettype wire

>>> hdl/akf_div.sv
// ----------------------------------------------------------------------------
// akf_div
// Restoring divider, one quotient bit a cycle: Q4.28 quotient num/den,
// rounded to nearest and saturated; zero when den is zero.
// ----------------------------------------------------------------------------
`default_nettype none
module akf_div
   import akf_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic signed [DataWidth-1:0] num,
   input  wire logic signed [DataWidth-1:0] den,
   output logic                             done,
   output logic signed [DataWidth-1:0]      quot
);

   localparam int unsigned NumBits = 60;

   logic [NumBits-1:0] dvd_ff, dvd_in;
   logic [32:0]        rem_ff, rem_in;
   logic [32:0]        ad_ff, ad_in;
   logic [NumBits-1:0] q_ff, q_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               neg_ff, neg_in;
   logic               zero_ff, zero_in;
   logic               done_ff, done_in;
   logic signed [DataWidth-1:0] quot_ff, quot_in;
   logic [33:0]        trial;
   logic [32:0]        an;
   logic [NumBits:0]   qr;

   always_comb begin
      dvd_in = dvd_ff; rem_in = rem_ff; ad_in = ad_ff; q_in = q_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; neg_in = neg_ff; zero_in = zero_ff;
      done_in = 1'b0; quot_in = quot_ff;
      trial = 34'(rem_ff) * 34'd2 + 34'(dvd_ff[NumBits-1]) - 34'(ad_ff);
      an = num[DataWidth-1] ? 33'(-34'(num)) : 33'(num);
      qr = '0;
      if (start) begin
         // Numerator magnitude is shifted up by 28; the quotient is rounded
         // from the final remainder.
         ad_in   = den[DataWidth-1] ? 33'(-34'(den)) : 33'(den);
         dvd_in  = NumBits'({an, 28'd0}) ;
         rem_in  = '0;
         q_in    = '0;
         cnt_in  = 6'd0;
         neg_in  = num[DataWidth-1] ^ den[DataWidth-1];
         zero_in = (den == '0);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[33]) begin
            rem_in = trial[32:0];
            q_in   = {q_ff[NumBits-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[31:0], dvd_ff[NumBits-1]};
            q_in   = {q_ff[NumBits-2:0], 1'b0};
         end
         dvd_in = {dvd_ff[NumBits-2:0], 1'b0};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(NumBits - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            // Round: compare twice the remainder with the divisor.
            qr = (NumBits+1)'(q_in) +
                 (NumBits+1)'({rem_in, 1'b0} >= {1'b0, ad_ff});
            if (zero_ff) begin
               quot_in = '0;
            end else begin
               quot_in = sat32(neg_ff ? -68'(qr) : 68'(qr));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in; rem_ff <= rem_in; ad_ff <= ad_in; q_ff <= q_in;
      cnt_ff <= cnt_in; neg_ff <= neg_in; zero_ff <= zero_in; quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule
`default_nettype wire

>>> hdl/angle_kalman_filter.sv
// ----------------------------------------------------------------------------
// angle_kalman_filter
// Two-state angle and gyro-bias Kalman filter in fixed point.
// ----------------------------------------------------------------------------
// Usage: present measured angle, gyro rate and time step on the req_ channel.
// One transfer is taken while the block is idle; req_ready then stays low
// until the result has been transferred on the rsp_ channel. Each item runs
// through a sequencer that drives one shared 33x33 multiplier (one product a
// cycle, with a registered product and rounded result) and a bit-serial
// divider that computes each of the two gains in turn. A stalled receiver
// keeps the result held in its register unless a start angle is written;
// no new item is taken until it is transferred. The csr_ channel writes the
// noise registers and the start angle (which loads the angle estimate); it
// is always ready and is to be used while the block is idle, which the
// block itself does not enforce. Reset restores the register defaults,
// clears bias and covariance and sets the angle estimate to zero.
// ----------------------------------------------------------------------------
`default_nettype none
module angle_kalman_filter
   import akf_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic signed [31:0]          req_measured_angle,
   input  wire logic signed [31:0]          req_measured_rate,
   input  wire logic [23:0]                 req_time_step,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic signed [31:0]               rsp_angle_estimate,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [CsrIdxWidth-1:0]      csr_index,
   input  wire logic [31:0]                 csr_data
);

   typedef enum logic [13:0] {
      ST_IDLE  = 14'b00000000000001,
      ST_RATE  = 14'b00000000000010,
      ST_M1    = 14'b00000000000100,
      ST_M2    = 14'b00000000001000,
      ST_M3    = 14'b00000000010000,
      ST_M4    = 14'b00000000100000,
      ST_M5    = 14'b00000001000000,
      ST_DIV0  = 14'b00000010000000,
      ST_DIV1  = 14'b00000100000000,
      ST_C1    = 14'b00001000000000,
      ST_C2    = 14'b00010000000000,
      ST_C3    = 14'b00100000000000,
      ST_C4    = 14'b01000000000000,
      ST_OUT   = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] step_ff, step_in;

   logic [NoiseWidth-1:0] qa_ff, qb_ff, r_ff;
   logic signed [31:0] ang_ff, ang_in, bias_ff, bias_in;
   logic signed [31:0] paa_ff, paa_in, pab_ff, pab_in, pba_ff, pba_in, pbb_ff, pbb_in;
   logic signed [31:0] ma_ff, ma_in, mr_ff, mr_in, rate_ff, rate_in;
   logic [23:0]        dt_ff, dt_in;
   logic signed [31:0] tmp_ff, tmp_in, k0_ff, k0_in, k1_ff, k1_in, y_ff, y_in;
   logic signed [31:0] s_ff, s_in, p00_ff, p00_in, p01_ff, p01_in;
   logic               rv_ff, rv_in;

   mul_req_type        mreq;
   logic signed [67:0] mres;
   logic               dstart, ddone;
   logic signed [31:0] dnum, dquot;

   akf_mul u_mul (.clock(clock), .req(mreq), .result(mres));
   akf_div u_div (.clock(clock), .reset(reset), .start(dstart), .num(dnum),
                  .den(s_ff), .done(ddone), .quot(dquot));

   assign req_ready = (state_ff == ST_IDLE) && !rv_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rv_ff;
   assign rsp_angle_estimate = ang_ff;

   // Each of the multiply states M1 to M4 issues in step 0 and consumes the result in step 2.
   always_comb begin
      state_in = state_ff; step_in = step_ff;
      ang_in = ang_ff; bias_in = bias_ff;
      paa_in = paa_ff; pab_in = pab_ff; pba_in = pba_ff; pbb_in = pbb_ff;
      ma_in = ma_ff; mr_in = mr_ff; dt_in = dt_ff; rate_in = rate_ff;
      tmp_in = tmp_ff; k0_in = k0_ff; k1_in = k1_ff; y_in = y_ff; s_in = s_ff;
      p00_in = p00_ff; p01_in = p01_ff; rv_in = rv_ff;
      mreq.a = '0; mreq.b = '0; mreq.shift = SHIFT_24;
      dstart = 1'b0; dnum = paa_ff;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               ma_in = req_measured_angle; mr_in = req_measured_rate;
               dt_in = req_time_step; state_in = ST_RATE;
            end
         end
         ST_RATE: begin
            rate_in = sat32(68'(mr_ff) - 68'(bias_ff));
            step_in = 3'd0; state_in = ST_M1;
         end
         ST_M1: begin
            mreq.a = 33'(rate_ff); mreq.b = 33'(dt_ff);
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd2) begin
               ang_in = sat32(68'(ang_ff) + mres);
               step_in = 3'd0; state_in = ST_M2;
            end
         end
         ST_M2: begin
            mreq.a = 33'(pbb_ff); mreq.b = 33'(dt_ff);
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd2) begin
               tmp_in = sat32(mres);
               step_in = 3'd0; state_in = ST_M3;
            end
         end
         ST_M3: begin
            // Inner term dt*Pbb - Pab - Pba + Qa, times dt.
            mreq.a = 33'(sat32(68'(tmp_ff) - 68'(pab_ff) - 68'(pba_ff) + 68'(qa_ff)));
            mreq.b = 33'(dt_ff);
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd2) begin
               paa_in = sat32(68'(paa_ff) + mres);
               pab_in = sat32(68'(pab_ff) - 68'(tmp_ff));
               pba_in = sat32(68'(pba_ff) - 68'(tmp_ff));
               step_in = 3'd0; state_in = ST_M4;
            end
         end
         ST_M4: begin
            mreq.a = 33'(qb_ff); mreq.b = 33'(dt_ff);
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd2) begin
               pbb_in = sat32(68'(pbb_ff) + mres);
               s_in = sat32(68'(paa_ff) + 68'(r_ff));
               y_in = sat32(68'(ma_ff) - 68'(ang_ff));
               step_in = 3'd0; state_in = ST_M5;
            end
         end
         ST_M5: begin
            dstart = 1'b1; dnum = paa_ff; state_in = ST_DIV0;
         end
         ST_DIV0: begin
            if (ddone) begin
               k0_in = dquot; dstart = 1'b1; dnum = pba_ff; state_in = ST_DIV1;
            end
         end
         ST_DIV1: begin
            if (ddone) begin
               k1_in = dquot; p00_in = paa_ff; p01_in = pab_ff;
               step_in = 3'd0; state_in = ST_C1;
            end
         end
         ST_C1: begin
            // Pipelined: issue k0*y and k1*y; ST_C2 issues k0*p00, k0*p01, k1*p00, k1*p01.
            mreq.shift = SHIFT_28;
            case (step_ff)
               3'd0: begin mreq.a = 33'(k0_ff); mreq.b = 33'(y_ff); end
               3'd1: begin mreq.a = 33'(k1_ff); mreq.b = 33'(y_ff); end
               3'd2: begin mreq.a = 33'(k0_ff); mreq.b = 33'(p00_ff); end
               3'd3: begin mreq.a = 33'(k0_ff); mreq.b = 33'(p01_ff); end
               3'd4: begin mreq.a = 33'(k1_ff); mreq.b = 33'(p00_ff); end
               3'd5: begin mreq.a = 33'(k1_ff); mreq.b = 33'(p01_ff); end
               default: begin mreq.a = '0; mreq.b = '0; end
            endcase
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd1) state_in = ST_C2;
         end
         ST_C2: begin
            // Results come back through the product and result registers of the multiplier.
            mreq.shift = SHIFT_28;
            case (step_ff)
               3'd2: begin mreq.a = 33'(k0_ff); mreq.b = 33'(p00_ff);
                  ang_in = sat32(68'(ang_ff) + mres); end
               3'd3: begin mreq.a = 33'(k0_ff); mreq.b = 33'(p01_ff);
                  bias_in = sat32(68'(bias_ff) + mres); end
               3'd4: begin mreq.a = 33'(k1_ff); mreq.b = 33'(p00_ff);
                  paa_in = sat32(68'(paa_ff) - mres); end
               3'd5: begin mreq.a = 33'(k1_ff); mreq.b = 33'(p01_ff);
                  pab_in = sat32(68'(pab_ff) - mres); end
               3'd6: pba_in = sat32(68'(pba_ff) - mres);
               default: pbb_in = sat32(68'(pbb_ff) - mres);
            endcase
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd7) state_in = ST_OUT;
         end
         ST_OUT: begin
            rv_in = 1'b1; state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (csr_valid && csr_ready && csr_index == CSR_START) ang_in = csr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; step_ff <= '0; rv_ff <= 1'b0;
         qa_ff <= ANGLE_Q_RESET; qb_ff <= BIAS_Q_RESET; r_ff <= MEAS_R_RESET;
         ang_ff <= '0; bias_ff <= '0;
         paa_ff <= '0; pab_ff <= '0; pba_ff <= '0; pbb_ff <= '0;
      end else begin
         state_ff <= state_in; step_ff <= step_in; rv_ff <= rv_in;
         ang_ff <= ang_in; bias_ff <= bias_in;
         paa_ff <= paa_in; pab_ff <= pab_in; pba_ff <= pba_in; pbb_ff <= pbb_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ANGLE_Q: qa_ff <= csr_data[NoiseWidth-1:0];
               CSR_BIAS_Q:  qb_ff <= csr_data[NoiseWidth-1:0];
               CSR_MEAS_R:  r_ff  <= csr_data[NoiseWidth-1:0];
               default: ;
            endcase
         end
      end
      ma_ff <= ma_in; mr_ff <= mr_in; dt_ff <= dt_in; rate_ff <= rate_in;
      tmp_ff <= tmp_in; k0_ff <= k0_in; k1_ff <= k1_in; y_ff <= y_in;
      s_ff <= s_in; p00_ff <= p00_in; p01_ff <= p01_in;
   end

endmodule
`default_nettype wire

>>> tb/sv/angle_kalman_filter_test.sv
// ----------------------------------------------------------------------------
// angle_kalman_filter_test
// Self-checking testbench of the fixed-point angle and bias Kalman filter.
// Measurements are driven through the req_ channel and every angle estimate
// on the rsp_ channel is compared with a bit-exact fixed-point predictor.
// Noise registers and the start angle are rewritten between phases.
// ----------------------------------------------------------------------------
module angle_kalman_filter_test
   import akf_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WatchdogLimit = 20000;
   localparam int DrainCycles = 400;

   class angle_scoreboard;
      logic [30:0] angle_q, bias_q, meas_r;
      logic signed [31:0] start_angle;
      logic signed [31:0] angle_est, bias_est, p_aa, p_ab, p_ba, p_bb;
      logic signed [31:0] expected_angles[$];
      int failures;

      function new();
         angle_q = ANGLE_Q_RESET;
         bias_q = BIAS_Q_RESET;
         meas_r = MEAS_R_RESET;
         start_angle = 0;
         angle_est = 0;
         bias_est = 0;
         p_aa = 0; p_ab = 0; p_ba = 0; p_bb = 0;
         failures = 0;
      endfunction

      static function logic signed [31:0] clip(longint v);
         if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
         if (v < -64'sd2147483648) return 32'sh80000000;
         return v[31:0];
      endfunction

      // Right shift rounded to nearest, ties away from zero.
      static function longint round_shift(longint v, int n);
         longint m;
         m = (v < 0) ? -v : v;
         m = (m + (64'sd1 <<< (n - 1))) >>> n;
         return (v < 0) ? -m : m;
      endfunction

      // Q4.28 quotient, rounded and saturated; zero for a zero divisor.
      static function logic signed [31:0] gain_div(logic signed [31:0] num,
                                                   logic signed [31:0] den);
         longint n, d, an, ad, q;
         n = longint'(num) * 64'sd268435456;
         d = den;
         if (d == 0) return 0;
         an = (n < 0) ? -n : n;
         ad = (d < 0) ? -d : d;
         q = (an + ad / 2) / ad;
         return clip(((n < 0) != (d < 0)) ? -q : q);
      endfunction

      function void write_reg(logic [CsrIdxWidth-1:0] idx, logic [31:0] data);
         case (idx)
            CSR_ANGLE_Q: angle_q = data[30:0];
            CSR_BIAS_Q:  bias_q = data[30:0];
            CSR_MEAS_R:  meas_r = data[30:0];
            CSR_START: begin
               start_angle = data;
               angle_est = data;
            end
            default: ;
         endcase
      endfunction

      function void note_measurement(logic signed [31:0] m_angle,
                                     logic signed [31:0] m_rate, logic [23:0] step);
         longint dt;
         logic signed [31:0] rate, dtpbb, inner, s, k0, k1, y, p00, p01;
         dt = {40'd0, step};
         rate = clip(longint'(m_rate) - bias_est);
         angle_est = clip(longint'(angle_est) + round_shift(dt * rate, 24));
         dtpbb = clip(round_shift(dt * p_bb, 24));
         inner = clip(longint'(dtpbb) - p_ab - p_ba + longint'({1'b0, angle_q}));
         p_aa = clip(longint'(p_aa) + round_shift(dt * inner, 24));
         p_ab = clip(longint'(p_ab) - dtpbb);
         p_ba = clip(longint'(p_ba) - dtpbb);
         p_bb = clip(longint'(p_bb) + round_shift(longint'({1'b0, bias_q}) * dt, 24));
         s = clip(longint'(p_aa) + longint'({1'b0, meas_r}));
         k0 = gain_div(p_aa, s);
         k1 = gain_div(p_ba, s);
         y = clip(longint'(m_angle) - angle_est);
         angle_est = clip(longint'(angle_est) + round_shift(longint'(k0) * y, 28));
         bias_est = clip(longint'(bias_est) + round_shift(longint'(k1) * y, 28));
         p00 = p_aa;
         p01 = p_ab;
         p_aa = clip(longint'(p_aa) - round_shift(longint'(k0) * p00, 28));
         p_ab = clip(longint'(p_ab) - round_shift(longint'(k0) * p01, 28));
         p_ba = clip(longint'(p_ba) - round_shift(longint'(k1) * p00, 28));
         p_bb = clip(longint'(p_bb) - round_shift(longint'(k1) * p01, 28));
         expected_angles.push_back(angle_est);
      endfunction

      function void check_estimate(logic signed [31:0] actual);
         logic signed [31:0] want;
         if (expected_angles.size() == 0) begin
            $error("angle_estimate: unexpected result %0d", actual);
            failures++;
            return;
         end
         want = expected_angles.pop_front();
         if (actual !== want) begin
            $error("angle_estimate: expected %0d, actual %0d", want, actual);
            failures++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_measured_angle = '0;
   logic signed [31:0] req_measured_rate = '0;
   logic [23:0] req_time_step = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_angle_estimate;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   angle_scoreboard board = new();
   bit quiet_phase = 0;
   bit long_hold = 0;
   int idle_cycles = 0;

   angle_kalman_filter dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) board.check_estimate(rsp_angle_estimate);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchdogLimit) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // Receiver: random stall bursts, one long hold-off, none at the end.
   initial begin
      int n;
      @(negedge clock);
      wait (!reset);
      forever begin
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (600) @(negedge clock);
            long_hold = 0;
         end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 10);
            rsp_ready <= 1'b0;
            repeat (n) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // Valid stays high from one transfer into the next; a gap or a wait for
   // the results lowers it.
   task automatic send_item(logic [31:0] a, logic [31:0] r, logic [23:0] dt);
      csr_valid <= 1'b0;
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_measured_angle <= a;
      req_measured_rate <= r;
      req_time_step <= dt;
      do @(posedge clock); while (!req_ready);
      board.note_measurement(a, r, dt);
      @(negedge clock);
   endtask

   task automatic write_csr(logic [CsrIdxWidth-1:0] idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, data);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      while (board.expected_angles.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return $urandom_range(0, 65535 * 8) - 32'd262144;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [23:0] rand_step();
      case ($urandom_range(0, 4))
         0: return 24'hFFFFFF;
         1: return 24'd0;
         2: return 24'($urandom_range(10000, 30000));
         default: return 24'($urandom);
      endcase
   endfunction

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: field extremes, default registers.
      send_item(32'h0, 32'h0, 24'h0);
      send_item(32'h7FFFFFFF, 32'h7FFFFFFF, 24'hFFFFFF);
      send_item(32'h80000000, 32'h80000000, 24'hFFFFFF);
      send_item(32'h00010000, 32'hFFFF0000, 24'd16777);
      send_item(32'hFFFFFFFF, 32'h00000001, 24'd1);
      wait_idle();
      // Zero measurement and process noise with a new start angle.
      write_csr(CSR_MEAS_R, 32'd0);
      write_csr(CSR_ANGLE_Q, 32'd0);
      write_csr(CSR_BIAS_Q, 32'd0);
      write_csr(CSR_START, 32'h00050000);
      send_item(32'h00100000, 32'h00020000, 24'd0);
      send_item(32'h00100000, 32'h00020000, 24'd16777);
      wait_idle();
      write_csr(CSR_ANGLE_Q, 32'h7FFFFFFF);
      write_csr(CSR_BIAS_Q, 32'h7FFFFFFF);
      write_csr(CSR_MEAS_R, 32'd1);
      write_csr(CSR_START, 32'h80000000);
      send_item(32'h7FFFFFFF, 32'h80000000, 24'hFFFFFF);
      send_item(32'h80000000, 32'h7FFFFFFF, 24'hFFFFFF);
      send_item(32'h12345678, 32'hEDCBA987, 24'h800000);
      wait_idle();
      write_csr(CSR_MEAS_R, 32'hFFFFFFFF);
      write_csr(CSR_START, 32'h7FFFFFFF);
      send_item(32'h0, 32'h0, 24'd16777);
      send_item(32'h55555555, 32'hAAAAAAAA, 24'h555555);
      send_item(32'hAAAAAAAA, 32'h55555555, 24'hAAAAAA);
      wait_idle();

      // Random phases, each with its own register setting.
      for (int phase = 0; phase < 8; phase++) begin
         if (phase == 7) quiet_phase = 1;
         write_csr(CSR_ANGLE_Q, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 22));
         write_csr(CSR_BIAS_Q, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 22));
         write_csr(CSR_MEAS_R, ($urandom_range(0, 3) == 0) ? $urandom
                                                           : $urandom_range(1, 1 << 26));
         write_csr(CSR_START, rand_word());
         for (int i = 0; i < 250; i++) begin
            if (phase == 2 && i == 20) long_hold = 1;
            if (phase == 4 && i == 100) wait_idle();
            send_item(rand_word(), rand_word(), rand_step());
         end
         wait_idle();
      end

      repeat (DrainCycles) @(negedge clock);
      if (board.failures == 0 && board.expected_angles.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

>>> files.f
hdl/akf_pkg.sv
hdl/akf_mul.sv
hdl/akf_div.sv
hdl/angle_kalman_filter.sv
tb/sv/angle_kalman_filter_test.sv
